>>> src/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

   // pool geometry
   localparam int MAX_SLOTS = 64;
   localparam int IDX_W     = $clog2(MAX_SLOTS);
   localparam int CNT_W     = 7;
   localparam int GROUP_W   = 8;
   localparam int GROUPS    = MAX_SLOTS / GROUP_W;
   localparam int GRP_IDX_W = $clog2(GROUPS);
   localparam int BIT_IDX_W = $clog2(GROUP_W);

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_SLOT_LIMIT = 0;
   localparam logic [CNT_W-1:0] SLOT_LIMIT_RESET = CNT_W'(64);

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_FIRST = 2'd2,
      MODE_NEXT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_FULL         = 2'd1,
      STATUS_ALREADY_FREE = 2'd2,
      STATUS_RANGE        = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_SCAN = 2'd2
   } state_type;

   typedef struct packed {
      mode_type         mode;
      logic [IDX_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] result_slot;
      status_type       status;
      logic [CNT_W-1:0] used_count;
   } rsp_type;

endpackage

>>> src/bitmap_slot_allocator_top.sv
`timescale 1ns / 1ps

// channel   | ports                               | handshake
// ----------+-------------------------------------+--------------------------------
// request   | start, busy, req_data               | taken when start high, busy low
// response  | rsp_strobe, rsp_data                | one cycle, no back pressure
// registers | csr_psel/penable/pwrite/paddr/...   | apb write, pready tied high
//
// an item is latched on acceptance, then passes the read and scan states before its
// response; the next item can be taken in the cycle the response is shown, so items never overlap
// the map lives in a memory with a registered read: read, mask, then a two-level
// find-first (byte groups, then bit) before the write-back
// reset is synchronous; a valid flag makes the never-written map read as all zero
// the receiver cannot stall, so the response is never held

module bitmap_slot_allocator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bsa_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output bsa_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bsa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bsa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bsa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int MS = bsa_pkg::MAX_SLOTS;
   localparam int CW = bsa_pkg::CNT_W;
   localparam int IW = bsa_pkg::IDX_W;
   localparam int GW = bsa_pkg::GROUP_W;
   localparam int NG = bsa_pkg::GROUPS;

   // control state
   bsa_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      slot_limit_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic               map_valid_ff;
   logic               rsp_strobe_ff;

   // item payload
   bsa_pkg::mode_type  mode_ff;
   logic [IW-1:0]      idx_ff;
   logic [CW-1:0]      lim_ff;
   logic [MS-1:0]      mem_q_ff;
   logic [MS-1:0]      map_ff;
   logic [MS-1:0]      cand_ff, cand_in;
   logic [NG-1:0]      grp_any_ff, grp_any_in;
   bsa_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // map memory
   logic [MS-1:0]      map_mem [0:0];
   logic [MS-1:0]      map_new;
   logic               mem_we;

   // fsm outputs
   logic               accept;
   logic               do_read;
   logic               do_scan;

   logic               csr_wr;
   logic [CW-1:0]      eff_limit;
   logic [MS-1:0]      rd_map;
   logic [CW-1:0]      first_idx;

   logic [bsa_pkg::GRP_IDX_W-1:0] sel_grp;
   logic [bsa_pkg::BIT_IDX_W-1:0] sel_bit;
   logic [GW-1:0]                 sel_byte;
   logic                          found;
   logic [IW-1:0]                 hit;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready
                   & (csr_paddr[2] == 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_limit_ff <= bsa_pkg::SLOT_LIMIT_RESET;
      end else if (csr_wr) begin
         slot_limit_ff <= csr_pwdata[CW-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == 1'b0) begin
         csr_prdata = {{(bsa_pkg::CSR_DATA_W-CW){1'b0}}, slot_limit_ff};
      end
   end

   // limit saturates at pool size
   assign eff_limit = (slot_limit_ff > CW'(MS)) ? CW'(MS) : slot_limit_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bsa_pkg::ST_IDLE: begin
            if (start) state_in = bsa_pkg::ST_READ;
         end
         bsa_pkg::ST_READ: state_in = bsa_pkg::ST_SCAN;
         bsa_pkg::ST_SCAN: state_in = bsa_pkg::ST_IDLE;
         default:          state_in = bsa_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      busy    = 1'b1;
      do_read = 1'b0;
      do_scan = 1'b0;
      unique case (state_ff)
         bsa_pkg::ST_IDLE: busy    = 1'b0;
         bsa_pkg::ST_READ: do_read = 1'b1;
         bsa_pkg::ST_SCAN: do_scan = 1'b1;
         default:          busy    = 1'b1;
      endcase
   end

   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // latch the item and issue the map read
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_data.mode;
         idx_ff   <= req_data.slot_index;
         lim_ff   <= eff_limit;
         mem_q_ff <= map_mem[0];
      end
   end

   // never-written map reads as empty
   assign rd_map    = map_valid_ff ? mem_q_ff : '0;
   assign first_idx = (mode_ff == bsa_pkg::MODE_NEXT) ? ({1'b0, idx_ff} + CW'(1)) : '0;

   // candidate vector: free slots for allocate, used slots in window for searches
   always_comb begin
      for (int i = 0; i < MS; i++) begin
         if (mode_ff == bsa_pkg::MODE_ALLOC) begin
            cand_in[i] = ~rd_map[i] & (CW'(i) < lim_ff);
         end else begin
            cand_in[i] = rd_map[i] & (CW'(i) < lim_ff) & (CW'(i) >= first_idx);
         end
      end
      for (int g = 0; g < NG; g++) begin
         grp_any_in[g] = |cand_in[g*GW +: GW];
      end
   end

   always_ff @(posedge clock) begin
      if (do_read) begin
         map_ff     <= rd_map;
         cand_ff    <= cand_in;
         grp_any_ff <= grp_any_in;
      end
   end

   // lowest group, then lowest bit inside it
   always_comb begin
      sel_grp = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) sel_grp = bsa_pkg::GRP_IDX_W'(g);
      end
      sel_byte = cand_ff[sel_grp*GW +: GW];
      sel_bit  = '0;
      for (int b = GW - 1; b >= 0; b--) begin
         if (sel_byte[b]) sel_bit = bsa_pkg::BIT_IDX_W'(b);
      end
      found = |grp_any_ff;
      hit   = {sel_grp, sel_bit};
   end

   // result and write-back
   always_comb begin
      rsp_data_in.result_slot = lim_ff;
      rsp_data_in.status      = bsa_pkg::STATUS_OK;
      map_new                 = map_ff;
      mem_we                  = 1'b0;
      count_in                = count_ff;
      case (mode_ff)
         bsa_pkg::MODE_ALLOC: begin
            if (found) begin
               rsp_data_in.result_slot = {1'b0, hit};
               map_new[hit]            = 1'b1;
               mem_we                  = do_scan;
               count_in                = count_ff + CW'(1);
            end else begin
               rsp_data_in.status = bsa_pkg::STATUS_FULL;
            end
         end
         bsa_pkg::MODE_FREE: begin
            rsp_data_in.result_slot = {1'b0, idx_ff};
            if ({1'b0, idx_ff} >= lim_ff) begin
               rsp_data_in.status = bsa_pkg::STATUS_RANGE;
            end else if (!map_ff[idx_ff]) begin
               rsp_data_in.status = bsa_pkg::STATUS_ALREADY_FREE;
            end else begin
               map_new[idx_ff] = 1'b0;
               mem_we          = do_scan;
               count_in        = count_ff - CW'(1);
            end
         end
         default: begin
            if (found) rsp_data_in.result_slot = {1'b0, hit};
         end
      endcase
      rsp_data_in.used_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[0] <= map_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff  <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= do_scan;
         if (mem_we) map_valid_ff <= 1'b1;
         if (do_scan) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_scan) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // checks
   a_item_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy ##1 busy)
      else $error("item left the pipeline early");

   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(do_scan))
      else $error("response without a scan cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MS))
      else $error("slot count above pool size");

   a_no_write_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status != bsa_pkg::STATUS_OK)
      |-> rsp_data.used_count == $past(count_ff))
      else $error("count changed on a failed item");

   a_alloc_below_limit: assert property (@(posedge clock) disable iff (reset)
      do_scan && mem_we && (mode_ff == bsa_pkg::MODE_ALLOC)
      |-> ({1'b0, hit} < lim_ff) && !map_ff[hit])
      else $error("allocated slot not free or beyond limit");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import bsa_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // shadow of the allocator state
   logic [MAX_SLOTS-1:0]   used_map  = '0;
   logic [CNT_W-1:0]       in_use    = '0;
   logic [CNT_W-1:0]       limit_reg = SLOT_LIMIT_RESET;

   rsp_type                pending_slot_rsps[$];
   int                     error_count  = 0;
   int                     items_sent   = 0;
   int                     rsps_checked = 0;
   int                     full_seen    = 0;
   int                     free_seen    = 0;
   int                     range_seen   = 0;
   int                     cycle_count  = 0;

   bitmap_slot_allocator_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // limit saturated to the pool size
   function automatic logic [CNT_W-1:0] eff_limit();
      return (limit_reg > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : limit_reg;
   endfunction

   // lowest used slot in [from, lim), lim when none
   function automatic logic [CNT_W-1:0] first_used_from(int from, logic [CNT_W-1:0] lim);
      logic [CNT_W-1:0] found;
      found = lim;
      for (int i = MAX_SLOTS - 1; i >= 0; i--)
         if (i >= from && i < int'(lim) && used_map[i]) found = CNT_W'(i);
      return found;
   endfunction

   // expected response for one item, updating the shadow state
   function automatic rsp_type predict_slot_op(req_type req);
      rsp_type          rsp;
      logic [CNT_W-1:0] lim;
      int               free_slot;
      lim             = eff_limit();
      rsp.result_slot = lim;
      rsp.status      = STATUS_OK;
      case (req.mode)
         MODE_ALLOC: begin
            free_slot = -1;
            for (int i = MAX_SLOTS - 1; i >= 0; i--)
               if (i < int'(lim) && !used_map[i]) free_slot = i;
            if (free_slot < 0) begin
               rsp.status = STATUS_FULL;
            end else begin
               used_map[free_slot] = 1'b1;
               in_use              = in_use + 1'b1;
               rsp.result_slot     = CNT_W'(free_slot);
            end
         end
         MODE_FREE: begin
            rsp.result_slot = CNT_W'(req.slot_index);
            if (CNT_W'(req.slot_index) >= lim) begin
               rsp.status = STATUS_RANGE;
            end else if (!used_map[req.slot_index]) begin
               rsp.status = STATUS_ALREADY_FREE;
            end else begin
               used_map[req.slot_index] = 1'b0;
               in_use                   = in_use - 1'b1;
            end
         end
         MODE_FIRST: rsp.result_slot = first_used_from(0, lim);
         default:    rsp.result_slot = first_used_from(int'(req.slot_index) + 1, lim);
      endcase
      rsp.used_count = in_use;
      return rsp;
   endfunction

   // a used slot below the limit near a random point, random index if none
   function automatic logic [IDX_W-1:0] pick_used_slot();
      logic [CNT_W-1:0] lim;
      logic [IDX_W-1:0] pick;
      int               base;
      int               j;
      lim  = eff_limit();
      base = $urandom_range(MAX_SLOTS - 1);
      pick = IDX_W'($urandom_range(MAX_SLOTS - 1));
      for (int off = MAX_SLOTS - 1; off >= 0; off--) begin
         j = (base + off) % MAX_SLOTS;
         if (j < int'(lim) && used_map[j]) pick = IDX_W'(j);
      end
      return pick;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_slot_rsps.size() == 0) begin
            report_mismatch("response with nothing pending, result_slot",
                            int'(rsp_data.result_slot), -1);
         end else begin
            want = pending_slot_rsps.pop_front();
            rsps_checked++;
            if (rsp_data.result_slot !== want.result_slot)
               report_mismatch("result_slot", int'(rsp_data.result_slot),
                               int'(want.result_slot));
            if (rsp_data.status !== want.status)
               report_mismatch("status", int'(rsp_data.status), int'(want.status));
            if (rsp_data.used_count !== want.used_count)
               report_mismatch("used_count", int'(rsp_data.used_count),
                               int'(want.used_count));
            case (want.status)
               STATUS_FULL:         full_seen++;
               STATUS_ALREADY_FREE: free_seen++;
               STATUS_RANGE:        range_seen++;
               default: ;
            endcase
         end
      end
   end

   // send one item, called at a falling edge, returns at a falling edge
   task automatic send_slot_op(input mode_type mode, input logic [IDX_W-1:0] idx);
      req_type                    req;
      logic [$bits(req_type)-1:0] noise;
      req.mode       = mode;
      req.slot_index = idx;
      req_data       = req;
      start          = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pending_slot_rsps.push_back(predict_slot_op(req));
      items_sent++;
      @(negedge clock);
      start    = 1'b0;
      noise    = $bits(req_type)'($urandom);
      req_data = req_type'(noise);
   endtask

   task automatic idle_gap(input int pct);
      while (int'($urandom_range(99)) < pct) @(negedge clock);
   endtask

   // wait until every response is back plus the pipeline depth
   task automatic wait_drained();
      while (pending_slot_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // apb write of slot_limit then read back
   task automatic write_slot_limit(input logic [CNT_W-1:0] value);
      logic [CSR_DATA_W-1:0] wdata;
      wdata            = $urandom;
      wdata[CNT_W-1:0] = value;
      csr_paddr   = CSR_ADDR_W'(CSR_IDX_SLOT_LIMIT * 4);
      csr_pwdata  = wdata;
      csr_pwrite  = 1'b1;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      limit_reg = value;
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[CNT_W-1:0] !== limit_reg)
         report_mismatch("slot_limit readback", int'(csr_prdata[CNT_W-1:0]),
                         int'(limit_reg));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // mostly well-formed alloc/free traffic with drifting fill pressure
   task automatic run_random_ops(input int count, input int idle_pct, input int drain_every);
      int               alloc_bias;
      int               pick;
      mode_type         mode;
      logic [IDX_W-1:0] idx;
      alloc_bias = 50;
      for (int k = 0; k < count; k++) begin
         if (k % 50 == 0) begin
            case ($urandom_range(2))
               0:       alloc_bias = 15;
               1:       alloc_bias = 50;
               default: alloc_bias = 85;
            endcase
         end
         if (drain_every > 0 && k > 0 && k % drain_every == 0)
            while (pending_slot_rsps.size() != 0) @(negedge clock);
         idx  = IDX_W'($urandom_range(MAX_SLOTS - 1));
         pick = $urandom_range(99);
         if (pick < 8) begin
            // noise
            mode = mode_type'($urandom_range(3));
         end else if (pick < 65) begin
            if (int'($urandom_range(99)) < alloc_bias) begin
               mode = MODE_ALLOC;
            end else begin
               mode = MODE_FREE;
               if ($urandom_range(99) < 80) idx = pick_used_slot();
            end
         end else if (pick < 78) begin
            mode = MODE_FIRST;
         end else begin
            mode = MODE_NEXT;
            if ($urandom_range(1)) idx = pick_used_slot();
         end
         idle_gap(idle_pct);
         send_slot_op(mode, idx);
      end
   endtask

   // each operation on an empty and a lightly used pool
   task automatic test_directed_ops();
      send_slot_op(MODE_FIRST, '0);
      send_slot_op(MODE_NEXT,  IDX_W'(63));
      send_slot_op(MODE_FREE,  '0);
      send_slot_op(MODE_ALLOC, '0);
      send_slot_op(MODE_ALLOC, IDX_W'(63));
      send_slot_op(MODE_FIRST, IDX_W'(63));
      send_slot_op(MODE_NEXT,  '0);
      send_slot_op(MODE_NEXT,  IDX_W'(1));
      send_slot_op(MODE_FREE,  '0);
      send_slot_op(MODE_FREE,  '0);
      send_slot_op(MODE_ALLOC, '0);
   endtask

   // full pool, out of range, zero, saturated and lowered limits
   task automatic test_limit_edges();
      wait_drained();
      write_slot_limit(CNT_W'(2));
      send_slot_op(MODE_ALLOC, '0);
      send_slot_op(MODE_FREE,  IDX_W'(2));
      send_slot_op(MODE_FREE,  IDX_W'(63));
      wait_drained();
      write_slot_limit('0);
      send_slot_op(MODE_ALLOC, '0);
      send_slot_op(MODE_FREE,  '0);
      send_slot_op(MODE_FIRST, '0);
      send_slot_op(MODE_NEXT,  IDX_W'(5));
      wait_drained();
      write_slot_limit(CNT_W'(127));
      send_slot_op(MODE_ALLOC, '0);
      send_slot_op(MODE_FREE,  IDX_W'(63));
      send_slot_op(MODE_NEXT,  IDX_W'(63));
      wait_drained();
      write_slot_limit(CNT_W'(1));
      send_slot_op(MODE_FIRST, '0);
      send_slot_op(MODE_NEXT,  '0);
      send_slot_op(MODE_FREE,  IDX_W'(1));
   endtask

   // random traffic over several limits and idle patterns
   task automatic test_random_traffic();
      int limits[7] = '{64, 8, 127, 1, 37, 0, 100};
      int idles[7]  = '{0, 48, 0, 21, 48, 0, 21};
      int counts[7] = '{250, 250, 200, 150, 250, 30, 200};
      for (int p = 0; p < 7; p++) begin
         wait_drained();
         write_slot_limit(CNT_W'(limits[p]));
         run_random_ops(counts[p], idles[p], 0);
      end
   endtask

   // sender holds off until the pipeline is empty every few items
   task automatic test_drain_pauses();
      wait_drained();
      write_slot_limit(CNT_W'(12));
      run_random_ops(100, 21, 20);
   endtask

   // stimulus sequence
   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed_ops();
      test_limit_edges();
      test_random_traffic();
      test_drain_pauses();

      while (pending_slot_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d items across nine slot limits, %0d responses checked",
               items_sent, rsps_checked);
      $display("outcomes seen: %0d pool full, %0d already free, %0d out of range",
               full_seen, free_seen, range_seen);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
src/bsa_pkg.sv
src/bitmap_slot_allocator_top.sv
bench/tb_top.sv
